FILE: rtl/core/jd2c_pkg.sv
`timescale 1ns / 1ps
// shared widths, calendar constants and helper functions for the julian day converter
package jd2c_pkg;

    localparam int YEAR_W     = 16;
    localparam int MONTH_W    = 4;
    localparam int DOM_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SECOND_W   = 6;
    localparam int SOD_W      = 17;
    localparam int X_W        = 9;
    localparam int E_W        = 4;
    localparam int NE_W       = 23;

    localparam int unsigned GREG_START   = 2299161;
    localparam int unsigned GAP_FIRST    = 2299150;
    localparam int unsigned GAP_LAST     = 2299160;
    localparam int unsigned HALF_DAY     = 43200;
    localparam int unsigned LAST_SECOND  = 86399;
    localparam int unsigned ALPHA_BIAS   = 7468865;
    localparam int unsigned ALPHA_DIV    = 146097;
    localparam int unsigned B_BIAS       = 1524;
    localparam int unsigned C_MUL        = 100;
    localparam int unsigned C_BIAS       = 12210;
    localparam int unsigned C_DIV        = 36525;
    localparam int unsigned D_MUL        = 1461;
    localparam int unsigned E_MUL        = 10000;
    localparam int unsigned E_DIV        = 306001;
    localparam int unsigned YEAR_BIAS    = 4715;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned E_WRAP       = 14;
    localparam int unsigned E_OFF_LOW    = 1;
    localparam int unsigned E_OFF_HIGH   = 13;
    localparam int unsigned MONTH_FEB    = 2;

    // quotient width of the constant divider for an n_w bit dividend
    function automatic int quot_width(input int n_w, input int divisor);
        return n_w - ($clog2(divisor + 1) - 1);
    endfunction

    // floor(30.6001 * e)
    function automatic logic [X_W-1:0] month_offset(input logic [E_W-1:0] e);
        logic [X_W-1:0] v;
        unique case (e)
            4'd0:  v = 9'd0;
            4'd1:  v = 9'd30;
            4'd2:  v = 9'd61;
            4'd3:  v = 9'd91;
            4'd4:  v = 9'd122;
            4'd5:  v = 9'd153;
            4'd6:  v = 9'd183;
            4'd7:  v = 9'd214;
            4'd8:  v = 9'd244;
            4'd9:  v = 9'd275;
            4'd10: v = 9'd306;
            4'd11: v = 9'd336;
            4'd12: v = 9'd367;
            4'd13: v = 9'd397;
            4'd14: v = 9'd428;
            4'd15: v = 9'd459;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/jd2c_in_if.sv
`timescale 1ns / 1ps
// input channel: day number and second of day
interface jd2c_in_if #(
    parameter int DAY_BITS = 23
);
    import jd2c_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DAY_BITS-1:0]  day_number;
    logic [SOD_W-1:0]     second_of_day;

    modport source (
        output valid,
        output day_number,
        output second_of_day,
        input  ready
    );

    modport sink (
        input  valid,
        input  day_number,
        input  second_of_day,
        output ready
    );
endinterface

FILE: rtl/core/jd2c_out_if.sv
`timescale 1ns / 1ps
// output channel: calendar date and time of day
interface jd2c_out_if;
    import jd2c_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]         month;
    logic [DOM_W-1:0]           day_of_month;
    logic [HOUR_W-1:0]          hour;
    logic [MINUTE_W-1:0]        minute;
    logic [SECOND_W-1:0]        second;
    logic                       invalid;

    modport source (
        output valid,
        output year,
        output month,
        output day_of_month,
        output hour,
        output minute,
        output second,
        output invalid,
        input  ready
    );

    modport sink (
        input  valid,
        input  year,
        input  month,
        input  day_of_month,
        input  hour,
        input  minute,
        input  second,
        input  invalid,
        output ready
    );
endinterface

FILE: rtl/core/jd2c_cdiv.sv
`timescale 1ns / 1ps
// three stage divider by a constant: reciprocal estimate, remainder, correction
module jd2c_cdiv #(
    parameter int N_W     = 17,
    parameter int DIVISOR = 3600
) (
    input  logic                                              clk,
    input  logic [2:0]                                        adv,
    input  logic [N_W-1:0]                                    n,
    output logic [jd2c_pkg::quot_width(N_W, DIVISOR)-1:0]     q,
    output logic [$clog2(DIVISOR)-1:0]                        r
);
    localparam int T    = $clog2(DIVISOR + 1) - 1;
    localparam int NT   = N_W - T;
    localparam int P_W  = 2 * NT;
    localparam int R_W  = $clog2(DIVISOR);
    localparam int RE_W = $clog2(3 * DIVISOR);

    localparam logic [63:0]     MR_FULL = (64'd1 << N_W) / 64'(DIVISOR);
    localparam logic [NT-1:0]   MR      = MR_FULL[NT-1:0];
    localparam logic [N_W-1:0]  DIV_N   = N_W'(DIVISOR);
    localparam logic [RE_W-1:0] DIV_R   = RE_W'(DIVISOR);
    localparam logic [RE_W-1:0] DIV2_R  = RE_W'(2 * DIVISOR);

    logic [P_W-1:0]  prod_reg;
    logic [P_W-1:0]  prod_next;
    logic [N_W-1:0]  num_reg;
    logic [NT-1:0]   qe_reg;
    logic [NT-1:0]   qe_next;
    logic [N_W-1:0]  re_full;
    logic [RE_W-1:0] re_reg;
    logic [RE_W-1:0] re_next;
    logic [NT-1:0]   q_reg;
    logic [NT-1:0]   q_next;
    logic [R_W-1:0]  r_reg;
    logic [R_W-1:0]  r_next;

    // estimate never exceeds the true quotient and trails it by at most two
    assign prod_next = P_W'(n[N_W-1:T]) * P_W'(MR);
    assign qe_next   = prod_reg[P_W-1:NT];
    assign re_full   = num_reg - N_W'(qe_next) * DIV_N;
    assign re_next   = re_full[RE_W-1:0];

    always_comb
    begin
        priority if (re_reg >= DIV2_R)
        begin
            q_next = qe_reg + NT'(2);
            r_next = R_W'(re_reg - DIV2_R);
        end
        else if (re_reg >= DIV_R)
        begin
            q_next = qe_reg + NT'(1);
            r_next = R_W'(re_reg - DIV_R);
        end
        else
        begin
            q_next = qe_reg;
            r_next = R_W'(re_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg <= prod_next;
            num_reg  <= n;
        end
        if (adv[1])
        begin
            qe_reg <= qe_next;
            re_reg <= re_next;
        end
        if (adv[2])
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule

FILE: rtl/core/julian_day_to_calendar_date.sv
`timescale 1ns / 1ps
// julian day number and second of day to calendar date and time of day
// Converts a whole chronological day number floor(JD + 0.5) plus the seconds
// since civil midnight into year, month, day, hour, minute and second, using
// the Julian calendar before day 2299161 and the Gregorian calendar from then
// on. Instants in the October 1582 gap raise invalid and zero the date fields.
// A second count above 86399 is clamped to 86399. The block takes one
// transaction per clock while the output is not stalled. The date chain has
// 15 register stages: a front stage, three constant dividers of three stages
// each joined by the B and NC stages and by the D and NE stages for the sums
// and products between them, and an output stage. A stalled output only holds
// back stages that are full, so bubbles still fill.
module julian_day_to_calendar_date #(
    parameter int DAY_BITS = 23
) (
    input  logic        clk,
    input  logic        rst_n,
    jd2c_in_if.sink     stamp,
    jd2c_out_if.source  result
);
    import jd2c_pkg::*;

    localparam int DW      = DAY_BITS;
    localparam int NS      = 15;
    localparam int NA_W    = DW + 2;
    localparam int QA_W    = quot_width(NA_W, ALPHA_DIV);
    localparam int B_W     = DW + 1;
    localparam int NC_W    = DW + 8;
    localparam int QC_W    = quot_width(NC_W, C_DIV);
    localparam int DP_W    = QC_W + 11;
    localparam int D_W     = DP_W - 2;
    localparam int QE_W    = quot_width(NE_W, E_DIV);
    localparam int QH_W    = quot_width(SOD_W, SEC_PER_HOUR);
    localparam int RH_W    = $clog2(SEC_PER_HOUR);
    localparam int QM_W    = quot_width(RH_W, SEC_PER_MIN);
    localparam int RM_W    = $clog2(SEC_PER_MIN);

    localparam int ST_DIV1 = 1;
    localparam int ST_B    = 4;
    localparam int ST_NC   = 5;
    localparam int ST_C    = 6;
    localparam int ST_TIME = 7;
    localparam int ST_D    = 9;
    localparam int ST_NE   = 10;
    localparam int ST_E    = 11;

    typedef struct packed {
        logic [DW-1:0]       z;
        logic                greg;
        logic                gap;
        logic [SOD_W-1:0]    s;
        logic [B_W-1:0]      b;
        logic [NC_W-1:0]     nc;
        logic [YEAR_W-1:0]   c_lo;
        logic [X_W-1:0]      x;
        logic [NE_W-1:0]     ne;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } stage_t;

    logic [NS-1:0]       adv;
    logic [NS-1:0]       valid_reg;
    logic [NS-1:0]       valid_next;
    stage_t              stg_reg  [0:NS-2];
    stage_t              stg_next [0:NS-2];

    logic [SOD_W-1:0]    sec_sat;
    logic                gap_now;
    logic [NA_W-1:0]     alpha_num;
    logic [QA_W-1:0]     alpha_q;
    logic [QA_W-1:0]     alpha_adj;
    logic [B_W-1:0]      b_sum;
    logic [QC_W-1:0]     c_q;
    logic [DP_W-1:0]     d_prod;
    logic [D_W-1:0]      d_diff;
    logic [QE_W-1:0]     e_q;
    logic [QH_W-1:0]     hour_q;
    logic [RH_W-1:0]     hour_r;
    logic [QM_W-1:0]     min_q;
    logic [RM_W-1:0]     min_r;

    logic [E_W-1:0]      e_sel;
    logic [MONTH_W-1:0]  month_calc;
    logic [X_W-1:0]      dom_calc;
    logic [YEAR_W-1:0]   year_calc;

    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DOM_W-1:0]    dom_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [SECOND_W-1:0] second_reg;
    logic                invalid_reg;

    // a stage moves when it or any stage after it has room
    for (genvar k = 0; k < NS; k++)
    begin : g_adv
        assign adv[k] = result.ready || !(&valid_reg[NS-1:k]);
    end

    assign stamp.ready = adv[0];

    always_comb
    begin
        valid_next[0] = adv[0] ? stamp.valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // front stage
    assign sec_sat = (stamp.second_of_day > SOD_W'(LAST_SECOND)) ?
                     SOD_W'(LAST_SECOND) : stamp.second_of_day;

    assign gap_now = (stamp.day_number > DW'(GAP_FIRST) && stamp.day_number < DW'(GAP_LAST))
                  || (stamp.day_number == DW'(GAP_FIRST) && sec_sat >= SOD_W'(HALF_DAY))
                  || (stamp.day_number == DW'(GAP_LAST) && sec_sat < SOD_W'(HALF_DAY));

    // gregorian correction and chain arithmetic between dividers
    assign alpha_num = stg_reg[0].greg ?
                       {stg_reg[0].z, 2'b00} - NA_W'(ALPHA_BIAS) : '0;
    assign alpha_adj = alpha_q - (alpha_q >> 2);
    assign b_sum     = B_W'(stg_reg[ST_B-1].z) + B_W'(B_BIAS)
                     + (stg_reg[ST_B-1].greg ? B_W'(alpha_adj) + B_W'(1) : '0);
    assign d_prod    = DP_W'(c_q) * DP_W'(D_MUL);
    assign d_diff    = D_W'(stg_reg[ST_D-1].b) - d_prod[DP_W-1:2];

    always_comb
    begin
        stg_next[0]        = '0;
        stg_next[0].z      = stamp.day_number;
        stg_next[0].greg   = stamp.day_number >= DW'(GREG_START);
        stg_next[0].gap    = gap_now;
        stg_next[0].s      = sec_sat;
        for (int k = 1; k < NS-1; k++)
        begin
            stg_next[k] = stg_reg[k-1];
        end
        stg_next[ST_B].b         = b_sum;
        stg_next[ST_B].hour      = HOUR_W'(hour_q);
        stg_next[ST_NC].nc       = NC_W'(stg_reg[ST_NC-1].b) * NC_W'(C_MUL) - NC_W'(C_BIAS);
        stg_next[ST_TIME].minute = MINUTE_W'(min_q);
        stg_next[ST_TIME].second = SECOND_W'(min_r);
        stg_next[ST_D].c_lo      = YEAR_W'(c_q);
        stg_next[ST_D].x         = d_diff[X_W-1:0];
        stg_next[ST_NE].ne       = NE_W'(stg_reg[ST_NE-1].x) * NE_W'(E_MUL);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS-1; k++)
        begin
            if (adv[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    jd2c_cdiv #(
        .N_W     (NA_W),
        .DIVISOR (ALPHA_DIV)
    ) u_alpha_div (
        .clk (clk),
        .adv (adv[ST_DIV1+2:ST_DIV1]),
        .n   (alpha_num),
        .q   (alpha_q),
        .r   ()
    );

    jd2c_cdiv #(
        .N_W     (SOD_W),
        .DIVISOR (SEC_PER_HOUR)
    ) u_hour_div (
        .clk (clk),
        .adv (adv[ST_DIV1+2:ST_DIV1]),
        .n   (stg_reg[0].s),
        .q   (hour_q),
        .r   (hour_r)
    );

    jd2c_cdiv #(
        .N_W     (RH_W),
        .DIVISOR (SEC_PER_MIN)
    ) u_min_div (
        .clk (clk),
        .adv (adv[ST_B+2:ST_B]),
        .n   (hour_r),
        .q   (min_q),
        .r   (min_r)
    );

    jd2c_cdiv #(
        .N_W     (NC_W),
        .DIVISOR (C_DIV)
    ) u_c_div (
        .clk (clk),
        .adv (adv[ST_C+2:ST_C]),
        .n   (stg_reg[ST_C-1].nc),
        .q   (c_q),
        .r   ()
    );

    jd2c_cdiv #(
        .N_W     (NE_W),
        .DIVISOR (E_DIV)
    ) u_e_div (
        .clk (clk),
        .adv (adv[ST_E+2:ST_E]),
        .n   (stg_reg[ST_E-1].ne),
        .q   (e_q),
        .r   ()
    );

    // month, day and year from e
    assign e_sel      = e_q[E_W-1:0];
    assign month_calc = (e_sel < E_W'(E_WRAP)) ? e_sel - E_W'(E_OFF_LOW)
                                               : e_sel - E_W'(E_OFF_HIGH);
    assign dom_calc   = stg_reg[NS-2].x - month_offset(e_sel);
    assign year_calc  = stg_reg[NS-2].c_lo - YEAR_W'(YEAR_BIAS)
                      - YEAR_W'(month_calc > MONTH_W'(MONTH_FEB));

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            hour_reg    <= stg_reg[NS-2].hour;
            minute_reg  <= stg_reg[NS-2].minute;
            second_reg  <= stg_reg[NS-2].second;
            invalid_reg <= stg_reg[NS-2].gap;
            if (stg_reg[NS-2].gap)
            begin
                year_reg  <= '0;
                month_reg <= '0;
                dom_reg   <= '0;
            end
            else
            begin
                year_reg  <= year_calc;
                month_reg <= month_calc;
                dom_reg   <= dom_calc[DOM_W-1:0];
            end
        end
    end

    assign result.valid        = valid_reg[NS-1];
    assign result.year         = year_reg;
    assign result.month        = month_reg;
    assign result.day_of_month = dom_reg;
    assign result.hour         = hour_reg;
    assign result.minute       = minute_reg;
    assign result.second       = second_reg;
    assign result.invalid      = invalid_reg;

endmodule

FILE: rtl/core/jd2c_checker.sv
`timescale 1ns / 1ps
// port level checks on the converter result channel, bound to the top level
module jd2c_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic [jd2c_pkg::YEAR_W-1:0]    year,
    input logic [jd2c_pkg::MONTH_W-1:0]   month,
    input logic [jd2c_pkg::DOM_W-1:0]     day_of_month,
    input logic [jd2c_pkg::HOUR_W-1:0]    hour,
    input logic [jd2c_pkg::MINUTE_W-1:0]  minute,
    input logic [jd2c_pkg::SECOND_W-1:0]  second,
    input logic                           invalid
);
    import jd2c_pkg::*;

    // stalled transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable({year, month, day_of_month, hour, minute, second, invalid}))
        else $error("result changed while stalled");

    a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && invalid |-> year == '0 && month == '0 && day_of_month == '0)
        else $error("gap result carries a date");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !invalid |-> month >= MONTH_W'(1) && month <= MONTH_W'(12)
            && day_of_month >= DOM_W'(1))
        else $error("date out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> hour <= HOUR_W'(23) && minute <= MINUTE_W'(59)
            && second <= SECOND_W'(59))
        else $error("time of day out of range");

endmodule

bind julian_day_to_calendar_date jd2c_checker u_jd2c_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .year         (result.year),
    .month        (result.month),
    .day_of_month (result.day_of_month),
    .hour         (result.hour),
    .minute       (result.minute),
    .second       (result.second),
    .invalid      (result.invalid)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the julian day to calendar date converter
module testbench;
    import jd2c_pkg::*;

    localparam int DAY_BITS      = 23;
    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_ITEMS  = 500;
    localparam int CALM_FIRST    = 100;
    localparam int CALM_LAST     = 349;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DOM_W-1:0]         day_of_month;
        logic [HOUR_W-1:0]        hour;
        logic [MINUTE_W-1:0]      minute;
        logic [SECOND_W-1:0]      second;
        logic                     invalid;
    } calendar_t;

    typedef struct packed {
        logic [DAY_BITS-1:0] day;
        logic [SOD_W-1:0]    sod;
        logic                typed;
        calendar_t           want;
    } stimulus_row_t;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    jd2c_in_if #(.DAY_BITS(DAY_BITS)) stamp_if ();
    jd2c_out_if result_if ();

    julian_day_to_calendar_date #(
        .DAY_BITS(DAY_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stamp  (stamp_if),
        .result (result_if)
    );

    calendar_t pending_dates[$];
    int        mismatches   = 0;
    bit        calm         = 1'b0;
    bit        hold_off_req = 1'b0;

    // typed rows: start of count, gregorian switch, j2000, calendar gap
    stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
        '{0,       0,      1'b1, '{-4712, 1, 1, 0, 0, 0, 0}},
        '{0,       86399,  1'b1, '{-4712, 1, 1, 23, 59, 59, 0}},
        '{1,       59,     1'b0, '0},
        '{2299161, 0,      1'b1, '{1582, 10, 15, 0, 0, 0, 0}},
        '{2299161, 86400,  1'b0, '0},
        '{2299160, 43200,  1'b1, '{1582, 10, 4, 12, 0, 0, 0}},
        '{2299160, 86400,  1'b0, '0},
        '{2299160, 43199,  1'b1, '{0, 0, 0, 11, 59, 59, 1}},
        '{2299159, 86399,  1'b1, '{0, 0, 0, 23, 59, 59, 1}},
        '{2299155, 131071, 1'b1, '{0, 0, 0, 23, 59, 59, 1}},
        '{2299151, 0,      1'b1, '{0, 0, 0, 0, 0, 0, 1}},
        '{2299150, 43200,  1'b1, '{0, 0, 0, 12, 0, 0, 1}},
        '{2299150, 131071, 1'b1, '{0, 0, 0, 23, 59, 59, 1}},
        '{2299150, 43199,  1'b0, '0},
        '{2299149, 86399,  1'b0, '0},
        '{2299162, 1,      1'b0, '0},
        '{2451545, 43200,  1'b1, '{2000, 1, 1, 12, 0, 0, 0}},
        '{1721424, 3600,   1'b0, '0},
        '{2400000, 3661,   1'b0, '0},
        '{4194303, 65535,  1'b0, '0},
        '{4194304, 65536,  1'b0, '0},
        '{8388607, 0,      1'b0, '0},
        '{8388607, 131071, 1'b0, '0}
    };

    function automatic calendar_t calendar_of(input logic [DAY_BITS-1:0] day,
                                              input logic [SOD_W-1:0] sod);
        longint    z;
        longint    s;
        longint    a;
        longint    alpha;
        longint    b;
        longint    c;
        longint    d;
        longint    e;
        longint    dom;
        longint    mon;
        longint    yr;
        calendar_t r;
        z = longint'(day);
        s = longint'(sod);
        if (s > longint'(LAST_SECOND))
        begin
            s = longint'(LAST_SECOND);
        end
        r.hour   = HOUR_W'(s / longint'(SEC_PER_HOUR));
        r.minute = MINUTE_W'((s % longint'(SEC_PER_HOUR)) / longint'(SEC_PER_MIN));
        r.second = SECOND_W'(s % longint'(SEC_PER_MIN));
        if ((z > longint'(GAP_FIRST) && z < longint'(GAP_LAST)) ||
            (z == longint'(GAP_FIRST) && s >= longint'(HALF_DAY)) ||
            (z == longint'(GAP_LAST) && s < longint'(HALF_DAY)))
        begin
            r.year         = '0;
            r.month        = '0;
            r.day_of_month = '0;
            r.invalid      = 1'b1;
            return r;
        end
        a = z;
        if (z >= longint'(GREG_START))
        begin
            alpha = (4 * z - longint'(ALPHA_BIAS)) / longint'(ALPHA_DIV);
            a = z + 1 + alpha - alpha / 4;
        end
        b   = a + longint'(B_BIAS);
        c   = (longint'(C_MUL) * b - longint'(C_BIAS)) / longint'(C_DIV);
        d   = (longint'(D_MUL) * c) / 4;
        e   = ((b - d) * longint'(E_MUL)) / longint'(E_DIV);
        dom = b - d - (longint'(E_DIV) * e) / longint'(E_MUL);
        mon = (e < longint'(E_WRAP)) ? e - longint'(E_OFF_LOW) : e - longint'(E_OFF_HIGH);
        yr  = c - longint'(YEAR_BIAS);
        if (mon > longint'(MONTH_FEB))
        begin
            yr = yr - 1;
        end
        r.year         = YEAR_W'(yr);
        r.month        = MONTH_W'(mon);
        r.day_of_month = DOM_W'(dom);
        r.invalid      = 1'b0;
        return r;
    endfunction

    task automatic offer(input logic [DAY_BITS-1:0] day, input logic [SOD_W-1:0] sod,
                         input calendar_t want);
        while (!calm && $urandom_range(99) < 10)
        begin
            stamp_if.valid <= 1'b0;
            @(posedge clk);
        end
        stamp_if.valid         <= 1'b1;
        stamp_if.day_number    <= day;
        stamp_if.second_of_day <= sod;
        @(posedge clk);
        while (!stamp_if.ready)
        begin
            @(posedge clk);
        end
        pending_dates.push_back(want);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        int                  pick;
        logic [DAY_BITS-1:0] day;
        logic [SOD_W-1:0]    sod;
        rst_n = 1'b0;
        stamp_if.valid         <= 1'b0;
        stamp_if.day_number    <= '0;
        stamp_if.second_of_day <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            offer(directed_rows[i].day, directed_rows[i].sod,
                  directed_rows[i].typed ? directed_rows[i].want
                                         : calendar_of(directed_rows[i].day,
                                                       directed_rows[i].sod));
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= CALM_FIRST && i <= CALM_LAST);
            if (i == HOLD_AT)
            begin
                hold_off_req = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                day = DAY_BITS'($urandom_range(2 ** DAY_BITS - 1));
                sod = SOD_W'($urandom_range(LAST_SECOND));
            end
            else if (pick < 75)
            begin
                // around the calendar gap and the gregorian switch
                day = DAY_BITS'($urandom_range(GREG_START + 15, GAP_FIRST - 10));
                if ($urandom_range(1))
                begin
                    sod = SOD_W'($urandom_range(HALF_DAY + 2, HALF_DAY - 2));
                end
                else
                begin
                    sod = SOD_W'($urandom_range(2 ** SOD_W - 1));
                end
            end
            else if (pick < 85)
            begin
                day = DAY_BITS'($urandom_range(2 ** DAY_BITS - 1));
                sod = SOD_W'($urandom_range(2 ** SOD_W - 1, LAST_SECOND - 100));
            end
            else
            begin
                if ($urandom_range(1))
                begin
                    day = DAY_BITS'($urandom_range(400));
                end
                else
                begin
                    day = DAY_BITS'((2 ** DAY_BITS - 1) - $urandom_range(400));
                end
                sod = SOD_W'($urandom_range(2 ** SOD_W - 1));
            end
            offer(day, sod, calendar_of(day, sod));
        end
        calm = 1'b0;
        stamp_if.valid <= 1'b0;

        while (pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // receiver: random stalls plus one long hold-off while the sender keeps offering
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_if.ready <= calm || ($urandom_range(99) >= 10);
            end
        end
    end

    always @(posedge clk)
    begin
        calendar_t got;
        calendar_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = '{result_if.year, result_if.month, result_if.day_of_month, result_if.hour,
                    result_if.minute, result_if.second, result_if.invalid};
            if (pending_dates.size() == 0)
            begin
                $display("%0t: result transaction with none expected, expected none, got %h",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("year", longint'($signed(want.year)), longint'($signed(got.year)));
                check_field("month", longint'(want.month), longint'(got.month));
                check_field("day_of_month", longint'(want.day_of_month),
                            longint'(got.day_of_month));
                check_field("hour", longint'(want.hour), longint'(got.hour));
                check_field("minute", longint'(want.minute), longint'(got.minute));
                check_field("second", longint'(want.second), longint'(got.second));
                check_field("invalid", longint'(want.invalid), longint'(got.invalid));
            end
        end
    end

    initial
    begin
        #1ms;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: julian_day_to_calendar_date.f
rtl/core/jd2c_pkg.sv
rtl/core/jd2c_in_if.sv
rtl/core/jd2c_out_if.sv
rtl/core/jd2c_cdiv.sv
rtl/core/julian_day_to_calendar_date.sv
rtl/core/jd2c_checker.sv
test/testbench.sv
